[rtl/lsa_pkg.sv]
// shared types and constants of the lifo stack allocator
package lsa_pkg;

  localparam int MAX_ENTRIES_DEF  = 32;
  localparam int HEADER_BYTES_DEF = 12;
  localparam int ADDR_BITS_DEF    = 32;

  localparam int HEADER_ALIGN = 4;
  localparam logic [3:0] HA_LOG2 = 4'($clog2(HEADER_ALIGN));

  localparam int DATA_W   = 32;
  localparam int HANDLE_W = 16;
  localparam int SUM_W    = DATA_W + 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_LENGTH = 1'd1;

  localparam logic [1:0] KIND_GRANTED = 2'd0;
  localparam logic [1:0] KIND_REFUSED = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;
  localparam logic [1:0] KIND_DONE    = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0]   prev;
    logic [DATA_W-1:0]   addr;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic             sub;
    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] b;
    logic [SUM_W-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             gt;
  } alu_rsp_t;

endpackage

[rtl/lsa_alu.sv]
// shared add, subtract and compare unit
module lsa_alu (
  input  lsa_pkg::alu_req_t req,
  output lsa_pkg::alu_rsp_t rsp
);
  import lsa_pkg::*;

  logic [SUM_W-1:0] b_eff;

  always_comb begin
    b_eff   = req.b ^ {SUM_W{req.sub}};
    rsp.sum = req.a + b_eff + SUM_W'(req.sub);
    rsp.gt  = rsp.sum > req.c;
  end

endmodule

[rtl/lsa_stack.sv]
// header stack memory with registered read
module lsa_stack #(
  parameter int DEPTH = lsa_pkg::MAX_ENTRIES_DEF,
  parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            we,
  input  logic [IW-1:0]   waddr,
  input  lsa_pkg::entry_t wdata,
  input  logic            re,
  input  logic [IW-1:0]   raddr,
  output lsa_pkg::entry_t rdata
);
  import lsa_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/lifo_stack_allocator.sv]
// lifo stack allocator top level with sequencer
// allocate: limit, align, size and header states in order; refused strobes from the header state, granted from commit
// free: each popped header passes a check and a pop state; a final check gives the done strobe
// one shared adder/compare unit does one step per cycle; busy is high while an item runs
// results are strobed for one cycle; the receiver cannot stall
// synchronous reset clears state, strobe, region registers, position to region base and the stack count
module lifo_stack_allocator #(
  parameter int MAX_ENTRIES  = lsa_pkg::MAX_ENTRIES_DEF,
  parameter int HEADER_BYTES = lsa_pkg::HEADER_BYTES_DEF,
  parameter int ADDR_BITS    = lsa_pkg::ADDR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [lsa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lsa_pkg::DATA_W-1:0]      cfg_data,
  input  logic                            start,
  output logic                            busy,
  input  logic                            func,
  input  logic [3:0]                      alignment_log2,
  input  logic [lsa_pkg::DATA_W-1:0]      request_size,
  input  logic [lsa_pkg::HANDLE_W-1:0]    release_handle,
  input  logic [lsa_pkg::DATA_W-1:0]      bookmark_address,
  output logic                            strobe,
  output logic [1:0]                      result_kind,
  output logic [lsa_pkg::DATA_W-1:0]      block_address,
  output logic [lsa_pkg::HANDLE_W-1:0]    released_handle,
  output logic [lsa_pkg::DATA_W-1:0]      current_position,
  output logic                            last
);
  import lsa_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [SUM_W-1:0] LIM_MAX = SUM_W'(1) << ADDR_BITS;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_LIMIT  = 8'b0000_0010,
    S_ALIGN  = 8'b0000_0100,
    S_SIZE   = 8'b0000_1000,
    S_HDR    = 8'b0001_0000,
    S_COMMIT = 8'b0010_0000,
    S_CHECK  = 8'b0100_0000,
    S_POP    = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic [DATA_W-1:0]    region_base, region_length;
  logic [ADDR_BITS-1:0] top_offset;
  logic [CW-1:0]        entry_count;

  logic [3:0]           lg_r;
  logic [DATA_W-1:0]    size_r;
  logic [HANDLE_W-1:0]  handle_r;
  logic [ADDR_BITS-1:0] mark_r;

  logic [SUM_W-1:0] limit_r, aligned_r, end_r;

  logic [ADDR_BITS-1:0] base_m, pos;
  logic [3:0]           lg_eff;
  logic [SUM_W-1:0]     amask;
  logic [CW-1:0]        cnt_dec;
  logic                 full;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  entry_t push_data, pop_data;
  logic   push_we, pop_re;

  logic [1:0]          res_kind;
  logic [DATA_W-1:0]   res_addr, res_pos;
  logic [HANDLE_W-1:0] res_handle;
  logic                res_last;

  assign base_m  = region_base[ADDR_BITS-1:0];
  assign pos     = base_m + top_offset;
  assign lg_eff  = (lg_r < HA_LOG2) ? HA_LOG2 : lg_r;
  assign amask   = (SUM_W'(1) << lg_eff) - SUM_W'(1);
  assign cnt_dec = entry_count - CW'(1);
  assign full    = entry_count == CW'(MAX_ENTRIES);
  assign busy    = state != S_IDLE;

  lsa_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign push_we   = state == S_COMMIT;
  assign pop_re    = state == S_CHECK;
  assign push_data = '{prev: DATA_W'(pos), addr: aligned_r[DATA_W-1:0], handle: handle_r};

  lsa_stack #(
    .DEPTH (MAX_ENTRIES),
    .IW    (IW)
  ) u_stack (
    .clk   (clk),
    .we    (push_we),
    .waddr (entry_count[IW-1:0]),
    .wdata (push_data),
    .re    (pop_re),
    .raddr (cnt_dec[IW-1:0]),
    .rdata (pop_data)
  );

  always_comb begin
    alu_req = '{sub: 1'b0, a: '0, b: '0, c: '0};
    case (state)
      S_LIMIT: begin
        alu_req.a = SUM_W'(base_m);
        alu_req.b = SUM_W'(region_length);
        alu_req.c = LIM_MAX;
      end
      S_ALIGN: begin
        alu_req.a = SUM_W'(pos);
        alu_req.b = amask;
      end
      S_SIZE: begin
        alu_req.a = aligned_r;
        alu_req.b = SUM_W'(size_r);
      end
      S_HDR: begin
        alu_req.a = end_r;
        alu_req.b = SUM_W'(HEADER_BYTES);
        alu_req.c = limit_r;
      end
      S_COMMIT: begin
        alu_req.sub = 1'b1;
        alu_req.a   = end_r;
        alu_req.b   = SUM_W'(base_m);
      end
      S_CHECK: begin
        alu_req.a = SUM_W'(pos);
        alu_req.c = SUM_W'(mark_r);
      end
      S_POP: begin
        alu_req.sub = 1'b1;
        alu_req.a   = SUM_W'(pop_data.prev[ADDR_BITS-1:0]);
        alu_req.b   = SUM_W'(base_m);
      end
      default: begin
        alu_req = '{sub: 1'b0, a: '0, b: '0, c: '0};
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = func ? S_CHECK : S_LIMIT;
        end
      end
      S_LIMIT:  state_next = S_ALIGN;
      S_ALIGN:  state_next = S_SIZE;
      S_SIZE:   state_next = S_HDR;
      S_HDR:    state_next = (alu_rsp.gt || full) ? S_IDLE : S_COMMIT;
      S_COMMIT: state_next = S_IDLE;
      S_CHECK:  state_next = (alu_rsp.gt && entry_count != '0) ? S_POP : S_IDLE;
      S_POP:    state_next = S_CHECK;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      region_base   <= '0;
      region_length <= '0;
      top_offset    <= '0;
      entry_count   <= '0;
      strobe        <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= 1'b0;
      if (cfg_write) begin
        case (cfg_index)
          CFG_REGION_BASE:   region_base   <= cfg_data;
          CFG_REGION_LENGTH: region_length <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_HDR: begin
          if (alu_rsp.gt || full) begin
            strobe <= 1'b1;
          end
        end
        S_COMMIT: begin
          top_offset  <= alu_rsp.sum[ADDR_BITS-1:0];
          entry_count <= entry_count + CW'(1);
          strobe      <= 1'b1;
        end
        S_CHECK: begin
          if (!alu_rsp.gt) begin
            strobe <= 1'b1;
          end else if (entry_count == '0) begin
            top_offset <= '0;
            strobe     <= 1'b1;
          end
        end
        S_POP: begin
          top_offset  <= alu_rsp.sum[ADDR_BITS-1:0];
          entry_count <= cnt_dec;
          strobe      <= pop_data.handle != '0;
        end
        default: ;
      endcase
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      lg_r     <= alignment_log2;
      size_r   <= request_size;
      handle_r <= release_handle;
      mark_r   <= bookmark_address[ADDR_BITS-1:0];
    end
    case (state)
      S_LIMIT: limit_r   <= alu_rsp.gt ? LIM_MAX : alu_rsp.sum;
      S_ALIGN: aligned_r <= alu_rsp.sum & ~amask;
      S_SIZE:  end_r     <= alu_rsp.sum;
      S_HDR: begin
        end_r      <= alu_rsp.sum;
        res_kind   <= KIND_REFUSED;
        res_addr   <= '0;
        res_handle <= '0;
        res_pos    <= DATA_W'(pos);
        res_last   <= 1'b1;
      end
      S_COMMIT: begin
        res_kind   <= KIND_GRANTED;
        res_addr   <= aligned_r[DATA_W-1:0];
        res_handle <= '0;
        res_pos    <= DATA_W'(end_r[ADDR_BITS-1:0]);
        res_last   <= 1'b1;
      end
      S_CHECK: begin
        res_kind   <= KIND_DONE;
        res_addr   <= '0;
        res_handle <= '0;
        res_pos    <= (alu_rsp.gt && entry_count == '0) ? DATA_W'(base_m) : DATA_W'(pos);
        res_last   <= 1'b1;
      end
      S_POP: begin
        res_kind   <= KIND_RELEASE;
        res_addr   <= pop_data.addr;
        res_handle <= pop_data.handle;
        res_pos    <= DATA_W'(pop_data.prev[ADDR_BITS-1:0]);
        res_last   <= 1'b0;
      end
      default: ;
    endcase
  end

  assign result_kind      = res_kind;
  assign block_address    = res_addr;
  assign released_handle  = res_handle;
  assign current_position = res_pos;
  assign last             = res_last;

endmodule
